// ----- design/rsp_pkg.sv -----
`timescale 1ns / 1ps

package rsp_pkg;

	// default geometry of the coordinate format
	localparam int RSP_COORD_WIDTH = 24;
	localparam int RSP_FRAC_BITS   = 16;

	// three axes per point
	localparam int AXES = 3;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OUTSIDE = 2'd1,
		ST_ZERO    = 2'd2
	} rsp_status_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ORIGIN_X = 2'd0,
		REG_ORIGIN_Y = 2'd1,
		REG_ORIGIN_Z = 2'd2,
		REG_RADIUS   = 2'd3
	} rsp_reg_t;

	// control that travels beside the data through every stage
	typedef struct packed {
		logic        valid;
		rsp_status_t status;
		logic        last;
	} rsp_side_t;

endpackage

// ----- design/rsp_if.sv -----
`timescale 1ns / 1ps

// direction beats into the block
interface rsp_pt_if import rsp_pkg::*; #(
	parameter int COORD_WIDTH = RSP_COORD_WIDTH
);
	logic                   valid;
	logic                   ready;
	logic [COORD_WIDTH-1:0] dir_x;
	logic [COORD_WIDTH-1:0] dir_y;
	logic [COORD_WIDTH-1:0] dir_z;
	logic                   last_point;

	modport source (output valid, dir_x, dir_y, dir_z, last_point, input ready);
	modport sink (input valid, dir_x, dir_y, dir_z, last_point, output ready);
endinterface

// projected point beats out of the block
interface rsp_hit_if import rsp_pkg::*; #(
	parameter int COORD_WIDTH = RSP_COORD_WIDTH
);
	logic                   valid;
	logic                   ready;
	logic [COORD_WIDTH-1:0] hit_x;
	logic [COORD_WIDTH-1:0] hit_y;
	logic [COORD_WIDTH-1:0] hit_z;
	rsp_status_t            status;
	logic                   last_out;

	modport source (output valid, hit_x, hit_y, hit_z, status, last_out, input ready);
	modport sink (input valid, hit_x, hit_y, hit_z, status, last_out, output ready);
endinterface

// register write channel
interface rsp_cfg_if import rsp_pkg::*; #(
	parameter int COORD_WIDTH = RSP_COORD_WIDTH
);
	logic                   valid;
	logic                   ready;
	rsp_reg_t               index;
	logic [COORD_WIDTH-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/ray_sphere_projection.sv -----
`timescale 1ns / 1ps

// Projects rays from a configured origin onto a sphere of configured radius
// centred at zero; each direction beat on pt gives one point beat on hit.
// Channels: pt carries dir_x/y/z and last_point, hit carries hit_x/y/z,
// status and last_out, cfg writes origin_x/y/z (index 0..2) and
// sphere_radius (index 3). cfg is always ready; write it only while idle.
// Stages: five setup stages, a square root stage per root bit
// (2*COORD_WIDTH), three scaling stages, a divider stage per quotient
// bit (COORD_WIDTH+1) and the output register.
// Throughput: one beat per cycle; every stage is a register slice.
// Stall: a result not taken waits in the output register while the next
// one lands in a skid register; with the skid full the pipeline freezes
// and pt.ready drops, so nothing is lost or repeated.
// Reset clears all valid bits, sets the origin to zero and the radius to
// 1.0 in the configured fixed point format.
// status: ok, origin not strictly inside (checked first), zero direction;
// error results give zero coordinates. Coordinates saturate.
module ray_sphere_projection import rsp_pkg::*; #(
	parameter int COORD_WIDTH = RSP_COORD_WIDTH,
	parameter int FRAC_BITS   = RSP_FRAC_BITS
) (
	input logic        clk,
	input logic        arst_n,
	rsp_pt_if.sink     pt,
	rsp_hit_if.source  hit,
	rsp_cfg_if.sink    cfg
);

	localparam int W  = COORD_WIDTH;
	localparam int P2 = 2 * W;
	localparam int RW = 4 * W;
	localparam int SW = 2 * W;
	localparam int QW = W + 1;
	localparam int PW = 3 * W;
	localparam int XS = P2 + (P2 + 1) + AXES * W;
	localparam int XD = 2 * AXES;
	localparam logic [W-2:0] RAD_RST = (W-1)'(64'd1 << FRAC_BITS);
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic [W-1:0] x;
		logic [W-1:0] y;
		logic [W-1:0] z;
		rsp_status_t  status;
		logic         last;
	} res_t;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? W'(-v) : v;
	endfunction

	// configuration registers
	logic signed [W-1:0] org_q [AXES];
	logic [W-2:0]        rad_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < AXES; k++) org_q[k] <= '0;
			rad_q <= RAD_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ORIGIN_X: org_q[0] <= cfg.data;
				REG_ORIGIN_Y: org_q[1] <= cfg.data;
				REG_ORIGIN_Z: org_q[2] <= cfg.data;
				REG_RADIUS:   rad_q    <= cfg.data[W-2:0];
			endcase
		end
	end

	// the whole pipeline moves while the skid register is free
	logic skid_valid_q;
	logic out_valid_q;
	logic adv;

	assign adv      = !skid_valid_q;
	assign pt.ready = adv;

	logic signed [W-1:0] din [AXES];
	assign din[0] = pt.dir_x;
	assign din[1] = pt.dir_y;
	assign din[2] = pt.dir_z;

	// s1: squares and products per axis
	rsp_side_t           side_s1;
	logic signed [W-1:0] d_s1  [AXES];
	logic [P2-1:0]       sq_s1 [AXES];
	logic [P2-1:0]       do_s1 [AXES];
	logic [P2-1:0]       oo_s1 [AXES];
	logic [P2-1:0]       rr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (adv) begin
			side_s1 <= '{valid: pt.valid, status: ST_OK, last: pt.last_point};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < AXES; k++) begin
				d_s1[k]  <= din[k];
				sq_s1[k] <= P2'(mag(din[k])) * P2'(mag(din[k]));
				do_s1[k] <= P2'(din[k]) * P2'(org_q[k]);
				oo_s1[k] <= P2'(mag(org_q[k])) * P2'(mag(org_q[k]));
			end
			rr_s1 <= P2'(rad_q) * P2'(rad_q);
		end
	end

	// s2: a = |d|^2, bh = d.o, c = |o|^2 - r^2
	rsp_side_t           side_s2;
	logic signed [W-1:0] d_s2 [AXES];
	logic [P2-1:0]       a_s2;
	logic [P2:0]         bh_s2;
	logic [P2:0]         c_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else if (adv) begin
			side_s2 <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s2  <= d_s1;
			a_s2  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			bh_s2 <= (P2+1)'($signed(do_s1[0])) + (P2+1)'($signed(do_s1[1]))
				+ (P2+1)'($signed(do_s1[2]));
			c_s2  <= {1'b0, oo_s1[0]} + {1'b0, oo_s1[1]} + {1'b0, oo_s1[2]}
				- {1'b0, rr_s1};
		end
	end

	// s3: status and partial products of bh^2 and a*|c|
	logic [P2-1:0] bhm_c;
	logic [P2-1:0] cm_c;
	rsp_status_t   st_c;

	assign bhm_c = bh_s2[P2] ? P2'(-bh_s2) : bh_s2[P2-1:0];
	assign cm_c  = P2'(-c_s2);

	always_comb begin
		if (!c_s2[P2]) st_c = ST_OUTSIDE;
		else if (a_s2 == '0) st_c = ST_ZERO;
		else st_c = ST_OK;
	end

	rsp_side_t           side_s3;
	logic signed [W-1:0] d_s3 [AXES];
	logic [P2-1:0]       a_s3;
	logic [P2:0]         bh_s3;
	logic [P2-1:0]       bb_ll_s3, bb_hl_s3, bb_hh_s3;
	logic [P2-1:0]       ac_ll_s3, ac_lh_s3, ac_hl_s3, ac_hh_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (adv) begin
			side_s3 <= '{valid: side_s2.valid, status: st_c, last: side_s2.last};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s3     <= d_s2;
			a_s3     <= a_s2;
			bh_s3    <= bh_s2;
			bb_ll_s3 <= P2'(bhm_c[W-1:0]) * P2'(bhm_c[W-1:0]);
			bb_hl_s3 <= P2'(bhm_c[P2-1:W]) * P2'(bhm_c[W-1:0]);
			bb_hh_s3 <= P2'(bhm_c[P2-1:W]) * P2'(bhm_c[P2-1:W]);
			ac_ll_s3 <= P2'(a_s2[W-1:0]) * P2'(cm_c[W-1:0]);
			ac_lh_s3 <= P2'(a_s2[W-1:0]) * P2'(cm_c[P2-1:W]);
			ac_hl_s3 <= P2'(a_s2[P2-1:W]) * P2'(cm_c[W-1:0]);
			ac_hh_s3 <= P2'(a_s2[P2-1:W]) * P2'(cm_c[P2-1:W]);
		end
	end

	// s4: assemble the two wide products
	rsp_side_t           side_s4;
	logic signed [W-1:0] d_s4 [AXES];
	logic [P2-1:0]       a_s4;
	logic [P2:0]         bh_s4;
	logic [RW-1:0]       bb_s4;
	logic [RW-1:0]       ac_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else if (adv) begin
			side_s4 <= side_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s4  <= d_s3;
			a_s4  <= a_s3;
			bh_s4 <= bh_s3;
			bb_s4 <= (RW'(bb_hh_s3) << P2) + (RW'(bb_hl_s3) << (W + 1)) + RW'(bb_ll_s3);
			ac_s4 <= (RW'(ac_hh_s3) << P2) + (RW'(ac_lh_s3) << W)
				+ (RW'(ac_hl_s3) << W) + RW'(ac_ll_s3);
		end
	end

	// s5: discriminant bh^2 - a*c
	rsp_side_t     side_s5;
	logic [RW-1:0] disc_s5;
	logic [XS-1:0] x_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s5 <= '0;
		end else if (adv) begin
			side_s5 <= side_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			disc_s5 <= bb_s4 + ac_s4;
			x_s5    <= {a_s4, bh_s4, d_s4[0], d_s4[1], d_s4[2]};
		end
	end

	// square root pipeline
	rsp_side_t     side_r;
	logic [SW-1:0] root_r;
	logic [XS-1:0] x_r;

	rsp_sqrt #(
		.RAD_WIDTH   (RW),
		.EXTRA_WIDTH (XS)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.side_in   (side_s5),
		.rad       (disc_s5),
		.extra_in  (x_s5),
		.side_out  (side_r),
		.root      (root_r),
		.extra_out (x_r)
	);

	logic [P2-1:0]       a_r;
	logic [P2:0]         bh_r;
	logic signed [W-1:0] d_r [AXES];

	assign a_r    = x_r[XS-1 -: P2];
	assign bh_r   = x_r[AXES*W +: P2+1];
	assign d_r[0] = x_r[2*W +: W];
	assign d_r[1] = x_r[W +: W];
	assign d_r[2] = x_r[0 +: W];

	// s6: numerator n = sqrt(disc) - bh
	rsp_side_t           side_s6;
	logic signed [W-1:0] d_s6 [AXES];
	logic [P2-1:0]       a_s6;
	logic [P2:0]         n_s6;
	logic [P2+1:0]       n_c;

	assign n_c = {2'b00, root_r} - {bh_r[P2], bh_r};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s6 <= '0;
		end else if (adv) begin
			side_s6 <= side_r;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s6 <= d_r;
			a_s6 <= a_r;
			n_s6 <= n_c[P2:0];
		end
	end

	// s7: partial products of n * |d| per axis
	rsp_side_t       side_s7;
	logic [AXES-1:0] neg_s7;
	logic [P2-1:0]   a_s7;
	logic [P2-1:0]   pl_s7 [AXES];
	logic [P2:0]     ph_s7 [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s7 <= '0;
		end else if (adv) begin
			side_s7 <= side_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s7 <= a_s6;
			for (int k = 0; k < AXES; k++) begin
				neg_s7[k] <= d_s6[k][W-1];
				pl_s7[k]  <= P2'(n_s6[W-1:0]) * P2'(mag(d_s6[k]));
				ph_s7[k]  <= (P2+1)'(n_s6[P2:W]) * (P2+1)'(mag(d_s6[k]));
			end
		end
	end

	// s8: full product, overflow check and divider operands
	logic [PW-1:0]   p_c   [AXES];
	logic [P2-1:0]   phi_c [AXES];
	logic [AXES-1:0] ovf_c;

	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			p_c[k]   = (PW'(ph_s7[k]) << W) + PW'(pl_s7[k]);
			phi_c[k] = {1'b0, p_c[k][PW-1:QW]};
			ovf_c[k] = (phi_c[k] >= a_s7);
		end
	end

	rsp_side_t       side_s8;
	logic [AXES-1:0] neg_s8;
	logic [AXES-1:0] ovf_s8;
	logic [P2-1:0]   a_s8;
	logic [P2-1:0]   hi_s8 [AXES];
	logic [QW-1:0]   lo_s8 [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s8 <= '0;
		end else if (adv) begin
			side_s8 <= side_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s8   <= a_s7;
			neg_s8 <= neg_s7;
			ovf_s8 <= ovf_c;
			for (int k = 0; k < AXES; k++) begin
				hi_s8[k] <= ovf_c[k] ? '0 : phi_c[k];
				lo_s8[k] <= p_c[k][QW-1:0];
			end
		end
	end

	// divider pipeline
	rsp_side_t       side_d;
	logic [QW-1:0]   quo_d [AXES];
	logic [XD-1:0]   x_d;
	logic [AXES-1:0] neg_d;
	logic [AXES-1:0] ovf_d;

	rsp_div #(
		.DEN_WIDTH   (P2),
		.QUO_WIDTH   (QW),
		.EXTRA_WIDTH (XD)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.side_in   (side_s8),
		.den       (a_s8),
		.rem_in    (hi_s8),
		.num_lo    (lo_s8),
		.extra_in  ({neg_s8, ovf_s8}),
		.side_out  (side_d),
		.quo       (quo_d),
		.extra_out (x_d)
	);

	assign neg_d = x_d[XD-1 -: AXES];
	assign ovf_d = x_d[AXES-1:0];

	// step along each axis from the origin, saturated
	logic signed [W+2:0] sum_c [AXES];
	logic [W-1:0]        val_c [AXES];
	res_t                res_c;

	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			sum_c[k] = neg_d[k] ? (W+3)'(org_q[k]) - $signed({2'b00, quo_d[k]})
				: (W+3)'(org_q[k]) + $signed({2'b00, quo_d[k]});
			if (side_d.status != ST_OK) val_c[k] = '0;
			else if (ovf_d[k]) val_c[k] = neg_d[k] ? MINV : MAXV;
			else if (sum_c[k][W+2:W-1] == '0 || sum_c[k][W+2:W-1] == '1)
				val_c[k] = sum_c[k][W-1:0];
			else val_c[k] = sum_c[k][W+2] ? MINV : MAXV;
		end
		res_c = '{x: val_c[0], y: val_c[1], z: val_c[2], status: side_d.status,
			last: side_d.last};
	end

	// output register with skid
	res_t out_q;
	res_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (adv && side_d.valid) begin
			if (!out_valid_q || hit.ready) out_valid_q <= 1'b1;
			else skid_valid_q <= 1'b1;
		end else if (out_valid_q && hit.ready) begin
			if (skid_valid_q) skid_valid_q <= 1'b0;
			else out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && side_d.valid) begin
			if (!out_valid_q || hit.ready) out_q <= res_c;
			else skid_q <= res_c;
		end else if (out_valid_q && hit.ready && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign hit.valid    = out_valid_q;
	assign hit.hit_x    = out_q.x;
	assign hit.hit_y    = out_q.y;
	assign hit.hit_z    = out_q.z;
	assign hit.status   = out_q.status;
	assign hit.last_out = out_q.last;

`ifndef ASSERT_OFF
	// skid holds a beat only behind a waiting output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");

	// skid fills only when the output beat was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !hit.ready))
		else $error("skid register filled without a stall");

	// error results carry zero coordinates
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(hit.valid && hit.status != ST_OK) |->
		(hit.hit_x == '0 && hit.hit_y == '0 && hit.hit_z == '0))
		else $error("error result with nonzero coordinates");
`endif

endmodule

// ----- design/rsp_sqrt.sv -----
`timescale 1ns / 1ps

// integer square root, one result bit per stage
module rsp_sqrt import rsp_pkg::*; #(
	parameter int RAD_WIDTH   = 4 * RSP_COORD_WIDTH,
	parameter int EXTRA_WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  rsp_side_t                side_in,
	input  logic [RAD_WIDTH-1:0]     rad,
	input  logic [EXTRA_WIDTH-1:0]   extra_in,
	output rsp_side_t                side_out,
	output logic [RAD_WIDTH/2-1:0]   root,
	output logic [EXTRA_WIDTH-1:0]   extra_out
);

	localparam int SW  = RAD_WIDTH / 2;
	localparam int RMW = SW + 2;
	localparam int TW  = SW + 4;

	logic [RAD_WIDTH-1:0]   rad_s   [SW];
	logic [RMW-1:0]         rem_s   [SW];
	logic [SW-1:0]          root_s  [SW];
	logic [EXTRA_WIDTH-1:0] extra_s [SW];
	rsp_side_t              side_s  [SW];

	for (genvar j = 0; j < SW; j++) begin : g_stage
		logic [RAD_WIDTH-1:0]   rad_c;
		logic [RMW-1:0]         rem_c;
		logic [SW-1:0]          root_c;
		logic [EXTRA_WIDTH-1:0] extra_c;
		rsp_side_t              side_c;
		logic [TW-1:0]          cur;
		logic [TW-1:0]          trial;
		logic                   fit;

		// stage input: block input or previous stage
		if (j == 0) begin : g_first
			assign rad_c   = rad;
			assign rem_c   = '0;
			assign root_c  = '0;
			assign extra_c = extra_in;
			assign side_c  = side_in;
		end else begin : g_next
			assign rad_c   = rad_s[j-1];
			assign rem_c   = rem_s[j-1];
			assign root_c  = root_s[j-1];
			assign extra_c = extra_s[j-1];
			assign side_c  = side_s[j-1];
		end

		// bring down two radicand bits and try the next root bit
		assign cur   = {rem_c, rad_c[RAD_WIDTH-1 -: 2]};
		assign trial = {2'b00, root_c, 2'b01};
		assign fit   = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[j] <= '0;
			end else if (en) begin
				side_s[j] <= side_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[j]   <= {rad_c[RAD_WIDTH-3:0], 2'b00};
				rem_s[j]   <= fit ? RMW'(cur - trial) : RMW'(cur);
				root_s[j]  <= {root_c[SW-2:0], fit};
				extra_s[j] <= extra_c;
			end
		end
	end

	assign side_out  = side_s[SW-1];
	assign root      = root_s[SW-1];
	assign extra_out = extra_s[SW-1];

endmodule

// ----- design/rsp_div.sv -----
`timescale 1ns / 1ps

// restoring divider, three lanes over one divisor, one quotient bit per stage
module rsp_div import rsp_pkg::*; #(
	parameter int DEN_WIDTH   = 2 * RSP_COORD_WIDTH,
	parameter int QUO_WIDTH   = RSP_COORD_WIDTH + 1,
	parameter int EXTRA_WIDTH = 2 * AXES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  rsp_side_t              side_in,
	input  logic [DEN_WIDTH-1:0]   den,
	input  logic [DEN_WIDTH-1:0]   rem_in [AXES],
	input  logic [QUO_WIDTH-1:0]   num_lo [AXES],
	input  logic [EXTRA_WIDTH-1:0] extra_in,
	output rsp_side_t              side_out,
	output logic [QUO_WIDTH-1:0]   quo [AXES],
	output logic [EXTRA_WIDTH-1:0] extra_out
);

	localparam int QW = QUO_WIDTH;
	localparam int DW = DEN_WIDTH;

	logic [DW-1:0]          den_s   [QW];
	logic [DW-1:0]          rem_s   [QW][AXES];
	// low numerator bits shift out at the top while quotient bits shift in
	logic [QW-1:0]          sh_s    [QW][AXES];
	logic [EXTRA_WIDTH-1:0] extra_s [QW];
	rsp_side_t              side_s  [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic [DW-1:0]          den_c;
		logic [DW-1:0]          rem_c   [AXES];
		logic [QW-1:0]          sh_c    [AXES];
		logic [EXTRA_WIDTH-1:0] extra_c;
		rsp_side_t              side_c;
		logic [DW:0]            t_c     [AXES];
		logic [AXES-1:0]        fit;

		if (j == 0) begin : g_first
			assign den_c   = den;
			assign rem_c   = rem_in;
			assign sh_c    = num_lo;
			assign extra_c = extra_in;
			assign side_c  = side_in;
		end else begin : g_next
			assign den_c   = den_s[j-1];
			assign rem_c   = rem_s[j-1];
			assign sh_c    = sh_s[j-1];
			assign extra_c = extra_s[j-1];
			assign side_c  = side_s[j-1];
		end

		// partial remainder against the divisor, per lane
		for (genvar k = 0; k < AXES; k++) begin : g_lane
			assign t_c[k] = {rem_c[k], sh_c[k][QW-1]};
			assign fit[k] = (t_c[k] >= {1'b0, den_c});

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j][k] <= fit[k] ? DW'(t_c[k] - {1'b0, den_c}) : DW'(t_c[k]);
					sh_s[j][k]  <= {sh_c[k][QW-2:0], fit[k]};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[j] <= '0;
			end else if (en) begin
				side_s[j] <= side_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j]   <= den_c;
				extra_s[j] <= extra_c;
			end
		end
	end

	assign side_out  = side_s[QW-1];
	assign quo       = sh_s[QW-1];
	assign extra_out = extra_s[QW-1];

endmodule
